/* rtl/spvd_pkg.sv */
// ----------------------------------------------------------------------------
// spvd_pkg: shared types and constants for the signed prefix varint decoder
// Token format between the front and back parts, form codes, lengths.
// ----------------------------------------------------------------------------
package spvd_pkg;

    typedef enum logic [2:0] {
        FORM_ONE   = 3'd0,
        FORM_TWO   = 3'd1,
        FORM_FOUR  = 3'd2,
        FORM_EIGHT = 3'd3,
        FORM_ESC   = 3'd4
    } t_form;

    // One classified byte on its way to the back part
    typedef struct packed {
        logic [7:0] data;
        logic       head;
        logic       last;
        t_form      form;
    } t_tok;

    localparam int TOK_W = $bits(t_tok);
    localparam int VALUE_W = 64;
    localparam int LEN_W = 4;
    localparam int RES_W = VALUE_W + LEN_W;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [LEN_W-1:0] LEN_ONE   = 4'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 4'd2;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 4'd4;
    localparam logic [LEN_W-1:0] LEN_EIGHT = 4'd8;
    localparam logic [LEN_W-1:0] LEN_ESC   = 4'd9;

    // Continuation bytes owed after each kind of head
    localparam logic [3:0] LEFT_TWO   = 4'd1;
    localparam logic [3:0] LEFT_FOUR  = 4'd3;
    localparam logic [3:0] LEFT_EIGHT = 4'd7;
    localparam logic [3:0] LEFT_ESC   = 4'd8;

endpackage

/* rtl/spvd_queue.sv */
// ----------------------------------------------------------------------------
// spvd_queue: small register FIFO
// Accepts a push while full is low; the oldest entry shows while empty is low.
// ----------------------------------------------------------------------------
module spvd_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/spvd_front.sv */
// ----------------------------------------------------------------------------
// spvd_front: byte classifier
// Tracks integer boundaries and tags each byte as head, continuation, last.
// ----------------------------------------------------------------------------
module spvd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output logic          o_tok_valid,
    output spvd_pkg::t_tok o_tok
);
    import spvd_pkg::*;

    logic [3:0] r_bytes_left, n_bytes_left;
    t_form      r_form, n_form;
    t_tok       tok;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_form       = r_form;
        tok.data     = i_byte;
        tok.head     = (r_bytes_left == 4'd0);
        tok.last     = 1'b0;
        tok.form     = r_form;
        if (r_bytes_left == 4'd0) begin
            if (i_byte[7]) begin
                n_form = FORM_ONE;
            end else if (i_byte[6]) begin
                n_form       = FORM_TWO;
                n_bytes_left = LEFT_TWO;
            end else if (i_byte[5]) begin
                n_form       = FORM_FOUR;
                n_bytes_left = LEFT_FOUR;
            end else if (i_byte[4]) begin
                n_form       = FORM_EIGHT;
                n_bytes_left = LEFT_EIGHT;
            end else begin
                n_form       = FORM_ESC;
                n_bytes_left = LEFT_ESC;
            end
            tok.form = n_form;
            tok.last = i_byte[7];
        end else begin
            n_bytes_left = r_bytes_left - 4'd1;
            tok.last     = (r_bytes_left == 4'd1);
        end
    end

    assign o_tok_valid = i_accept;
    assign o_tok       = tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 4'd0;
            r_form       <= FORM_ONE;
        end else if (i_accept) begin
            r_bytes_left <= n_bytes_left;
            r_form       <= n_form;
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left <= LEFT_ESC)
        else $error("bytes left out of range");

    a_escape_owes_eight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_bytes_left == 4'd0 && i_byte[7:4] == 4'd0)
            |=> (r_bytes_left == LEFT_ESC && r_form == FORM_ESC))
        else $error("escape head did not load eight bytes");

    a_cont_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_bytes_left != 4'd0)
            |=> (r_bytes_left == $past(r_bytes_left) - 4'd1 && $stable(r_form)))
        else $error("continuation did not count down");

endmodule

/* rtl/spvd_back.sv */
// ----------------------------------------------------------------------------
// spvd_back: value assembler
// Shifts bytes into the accumulator; on the last byte sign-extends every form but escape.
// ----------------------------------------------------------------------------
module spvd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tok_valid,
    input  spvd_pkg::t_tok                i_tok,
    output logic                          o_tok_pop,
    input  logic                          i_res_full,
    output logic                          o_res_push,
    output logic [spvd_pkg::VALUE_W-1:0]  o_res_value,
    output logic [spvd_pkg::LEN_W-1:0]    o_res_length
);
    import spvd_pkg::*;

    logic [VALUE_W-1:0] r_acc, n_acc;

    // Hold a last byte until the result queue has room
    assign o_tok_pop  = i_tok_valid && (!i_tok.last || !i_res_full);
    assign o_res_push = o_tok_pop && i_tok.last;

    always_comb begin
        if (i_tok.head) begin
            n_acc = (i_tok.form == FORM_ESC) ? '0 : {56'd0, i_tok.data};
        end else begin
            n_acc = {r_acc[VALUE_W-9:0], i_tok.data};
        end
        case (i_tok.form)
            FORM_ONE: begin
                o_res_value  = {{57{n_acc[6]}}, n_acc[6:0]};
                o_res_length = LEN_ONE;
            end
            FORM_TWO: begin
                o_res_value  = {{50{n_acc[13]}}, n_acc[13:0]};
                o_res_length = LEN_TWO;
            end
            FORM_FOUR: begin
                o_res_value  = {{35{n_acc[28]}}, n_acc[28:0]};
                o_res_length = LEN_FOUR;
            end
            FORM_EIGHT: begin
                o_res_value  = {{4{n_acc[59]}}, n_acc[59:0]};
                o_res_length = LEN_EIGHT;
            end
            default: begin
                o_res_value  = n_acc;
                o_res_length = LEN_ESC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_pop) begin
            r_acc <= n_acc;
        end
    end

    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (o_res_length == LEN_ONE || o_res_length == LEN_TWO ||
                        o_res_length == LEN_FOUR || o_res_length == LEN_EIGHT ||
                        o_res_length == LEN_ESC))
        else $error("illegal encoded length");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok_valid && i_tok.last && i_res_full) |-> !o_tok_pop)
        else $error("last byte consumed while result queue full");

    a_one_byte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok_valid && i_tok.head && i_tok.form == FORM_ONE) |-> i_tok.last)
        else $error("one-byte head not marked last");

endmodule

/* rtl/signed_prefix_varint_decoder_core.sv */
// ----------------------------------------------------------------------------
// signed_prefix_varint_decoder_core: signed prefix-length varint decoder
// Path: a transferred byte is registered in the mid queue and its result in the
//   result queue (front tags it, back assembles it into the result queue).
// Throughput: one byte per cycle while full is low.
// Reset: synchronous active-low; clears both queues and the byte counter,
//   so the first byte after reset is taken as a head byte.
// ----------------------------------------------------------------------------
module signed_prefix_varint_decoder_core #(
    parameter int MID_DEPTH = spvd_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = spvd_pkg::OUT_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // byte input side
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   i_in_byte,
    // result side
    output logic                         empty,
    input  logic                         pop,
    output logic signed [63:0]           o_value,
    output logic [3:0]                   o_encoded_length
);
    import spvd_pkg::*;

    // Front part: classify every transferred byte.
    // Mid queue: decouple classification from assembly.
    // Back part: assemble values into the result queue.

    logic                 accept;
    logic                 tok_push;
    t_tok                 tok_in;
    t_tok                 tok_out;
    logic [TOK_W-1:0]     tok_bits;
    logic                 mid_empty;
    logic                 tok_pop;
    logic                 res_push;
    logic                 res_full;
    logic [VALUE_W-1:0]   res_value;
    logic [LEN_W-1:0]     res_length;
    logic [RES_W-1:0]     res_bits;

    // A byte transfers in whenever the mid queue has room
    assign accept = push && !full;

    spvd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_in_byte),
        .o_tok_valid (tok_push),
        .o_tok       (tok_in)
    );

    spvd_queue #(
        .W     (TOK_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok_in),
        .o_full  (full),
        .i_pop   (tok_pop),
        .o_data  (tok_bits),
        .o_empty (mid_empty)
    );

    assign tok_out = t_tok'(tok_bits);

    spvd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_valid  (!mid_empty),
        .i_tok        (tok_out),
        .o_tok_pop    (tok_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res_value  (res_value),
        .o_res_length (res_length)
    );

    // Result queue: hold finished values while the consumer stalls
    spvd_queue #(
        .W     (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_value, res_length}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

    assign o_value          = signed'(res_bits[RES_W-1:LEN_W]);
    assign o_encoded_length = res_bits[LEN_W-1:0];

endmodule

/* verif/spvd_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spvd_tb_pkg: decoded-integer scoreboard for the varint decoder testbench
// Tracks the decode state byte by byte, queues the integers the decoder
// should produce and compares each transferred result with the oldest one.
// ----------------------------------------------------------------------------
package spvd_tb_pkg;

    import spvd_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  length;
    } t_decoded;

    class decoded_int_scoreboard;

        logic [3:0]  owed;
        logic [63:0] gathered;
        t_form       form;
        t_decoded    expected_ints[$];
        int          errors;

        function new();
            owed     = '0;
            gathered = '0;
            form     = FORM_ONE;
            errors   = 0;
        endfunction

        // keep the low nbits and sign-extend from the top one
        function logic [63:0] sign_extend(logic [63:0] v, int unsigned nbits);
            logic [63:0] mask;
            mask = (64'd1 << nbits) - 64'd1;
            v    = v & mask;
            if (v[nbits-1])
                v = v | ~mask;
            return v;
        endfunction

        function int pending();
            return expected_ints.size();
        endfunction

        // Advance the decode state by one transferred byte
        function void note_byte(logic [7:0] b);
            t_decoded d;
            if (owed == 4'd0) begin
                if (b[7]) begin
                    d.value  = sign_extend({56'd0, b}, 7);
                    d.length = LEN_ONE;
                    form     = FORM_ONE;
                    gathered = '0;
                    expected_ints.push_back(d);
                end else if (b[6]) begin
                    form     = FORM_TWO;
                    owed     = LEFT_TWO;
                    gathered = {56'd0, b};
                end else if (b[5]) begin
                    form     = FORM_FOUR;
                    owed     = LEFT_FOUR;
                    gathered = {56'd0, b};
                end else if (b[4]) begin
                    form     = FORM_EIGHT;
                    owed     = LEFT_EIGHT;
                    gathered = {56'd0, b};
                end else begin
                    // escape: the head byte is dropped from the value
                    form     = FORM_ESC;
                    owed     = LEFT_ESC;
                    gathered = '0;
                end
                return;
            end

            gathered = {gathered[55:0], b};
            owed     = owed - 4'd1;
            if (owed != 4'd0)
                return;

            case (form)
                FORM_TWO: begin
                    d.value  = sign_extend(gathered, 14);
                    d.length = LEN_TWO;
                end
                FORM_FOUR: begin
                    d.value  = sign_extend(gathered, 29);
                    d.length = LEN_FOUR;
                end
                FORM_EIGHT: begin
                    d.value  = sign_extend(gathered, 60);
                    d.length = LEN_EIGHT;
                end
                default: begin
                    d.value  = gathered;
                    d.length = LEN_ESC;
                end
            endcase
            gathered = '0;
            expected_ints.push_back(d);
        endfunction

        function void check_decoded(logic [63:0] value, logic [3:0] length);
            t_decoded d;
            if (expected_ints.size() == 0) begin
                $error("unexpected result: value %h, encoded_length %0d", value, length);
                errors++;
                return;
            end
            d = expected_ints.pop_front();
            if (value !== d.value) begin
                $error("value: expected %h, got %h", d.value, value);
                errors++;
            end
            if (length !== d.length) begin
                $error("encoded_length: expected %0d, got %0d", d.length, length);
                errors++;
            end
        endfunction

    endclass

endpackage

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: random and directed test of the signed prefix varint decoder
// Streams encoded integers of every form, plus stray bytes, through the
// decoder under several idling patterns on both sides and checks every
// decoded value and length against a byte-level scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    import spvd_pkg::*;
    import spvd_tb_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BYTES = 1925;
    localparam int NUM_PHASES   = 4;
    // idle time after the last drain, before the final check
    localparam int SETTLE_CYCLES = 6;

    // idle percentages per phase: none, sender, receiver, both
    localparam int SEND_IDLE [NUM_PHASES] = '{0, 80, 0, 11};
    localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 80, 11};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         i_in_byte = 8'd0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [63:0] o_value;
    logic [3:0]         o_encoded_length;

    decoded_int_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_bytes     = 0;
    int cycle_count    = 0;

    always #4 i_clk = ~i_clk;

    signed_prefix_varint_decoder_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_in_byte        (i_in_byte),
        .empty            (empty),
        .pop              (pop),
        .o_value          (o_value),
        .o_encoded_length (o_encoded_length)
    );

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: decide pop on the falling edge, stall at the phase's rate
    always @(negedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every result transferred out at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_decoded(o_value, o_encoded_length);
    end

    // Skew toward all-zero and all-one bytes now and then to hit payload extremes
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Transfer one byte in. Enter and leave on a falling edge; push stays
    // high on return so back-to-back bytes go without a bubble.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        do
            @(posedge i_clk);
        while (full);
        sb.note_byte(b);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    // Send one well-formed integer of a random form with random content
    task automatic send_random_int();
        logic [7:0] head;
        int         tail;
        head = pick_byte();
        case ($urandom_range(4))
            0: begin
                head = {1'b1, head[6:0]};
                tail = 0;
            end
            1: begin
                head = {2'b01, head[5:0]};
                tail = int'(LEFT_TWO);
            end
            2: begin
                head = {3'b001, head[4:0]};
                tail = int'(LEFT_FOUR);
            end
            3: begin
                head = {4'b0001, head[3:0]};
                tail = int'(LEFT_EIGHT);
            end
            default: begin
                // escape head: any low nibble
                head = {4'b0000, head[3:0]};
                tail = int'(LEFT_ESC);
            end
        endcase
        send_byte(head);
        repeat (tail)
            send_byte(pick_byte());
    endtask

    // Drop push and hold the sender until every expected result is out
    task automatic drain_results();
        push <= 1'b0;
        do
            @(negedge i_clk);
        while (sb.pending() != 0);
    endtask

    initial begin
        logic [7:0] directed_bytes[$];
        int         goal;

        sb = new();
        // one-byte extremes; two-byte max; four-byte min; eight-byte -1;
        // escape with a nonzero low nibble carrying the most negative value
        directed_bytes = '{8'h80, 8'hFF,
                           8'h5F, 8'hFF,
                           8'h30, 8'h00, 8'h00, 8'h00,
                           8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                           8'h0A, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                           8'h00};

        // Hold reset, then release it on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);
        drain_results();

        // Random phases; mostly whole integers, some stray bytes that land
        // mid-integer and shift the framing
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            goal = sent_bytes + RANDOM_BYTES / NUM_PHASES;
            while (sent_bytes < goal) begin
                if ($urandom_range(99) < 15)
                    send_byte(8'($urandom_range(255)));
                else
                    send_random_int();
            end
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
